// ===== rtl/mmf_pkg.sv =====
// Shared types and constants for the Montgomery multiplier.
`default_nettype none
package mmf_pkg;

  localparam int WORD_W = 64;
  localparam int HALF_W = 32;
  localparam int ACC_W = 3 * WORD_W;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_NEG_INV = 3'd4;

  typedef struct packed {
    logic [WORD_W-1:0] a_word;
    logic [WORD_W-1:0] b_word;
    logic              last_word;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] result_word;
    logic              last_result;
  } out_t;

  typedef enum logic [1:0] {
    SRC_AB,
    SRC_QN,
    SRC_Q0
  } src_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AB,
    ST_QN,
    ST_QWAIT,
    ST_QMUL,
    ST_QDRAIN,
    ST_QWRITE,
    ST_END,
    ST_SHIFT,
    ST_CMP,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       load_en;
    logic       count_clear;
    logic       acc_clear;
    logic       acc_shift;
    logic       mul_en;
    src_t       mul_src;
    logic [1:0] part;
    logic       qacc_clear;
    logic       q_write;
    logic       q_from_acc;
    logic       cmp_init;
    logic       cmp_en;
    logic       out_en;
    logic       out_first;
    logic       out_last;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/montgomery_multiplier_fips.sv =====
// Top level of the word-serial Montgomery multiplier.
`default_nettype none
// Load NUM_WORDS (a_word, b_word) beats, least significant first, one per cycle while busy
// is low; the beat with last_word set starts a*b*R^-1 mod n, R = 2^(64*NUM_WORDS). Beats
// past NUM_WORDS are dropped; missing high words count as zero. Program modulus words and
// n0 = -n^-1 mod 2^64 through the cfg channel while busy is low (index 0..3 modulus, 4 n0).
// All 64x64 products run through one shared 32x32 multiplier: each word MAC sums all four
// 32x32 partial products and each quotient word the three that reach its low 64 bits. Busy
// stays high until the last result beat is issued. Result words then come out one per cycle
// on result_strobe, least significant first, last_result on the top word; the receiver
// cannot stall, so each beat must be taken in the cycle it is shown.
module montgomery_multiplier_fips #(
  parameter int NUM_WORDS = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire mmf_pkg::in_t                     operand,
  output logic                                  result_strobe,
  output mmf_pkg::out_t                         result,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [mmf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [mmf_pkg::WORD_W-1:0]       cfg_data
);

  localparam int IW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  mmf_pkg::cmd_t cmd;
  logic [IW-1:0] j, k, q_widx;

  assign cfg_ready = 1'b1;

  mmf_ctrl #(
    .NUM_WORDS(NUM_WORDS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .last_word (operand.last_word),
    .busy      (busy),
    .cmd       (cmd),
    .j         (j),
    .k         (k),
    .q_widx    (q_widx)
  );

  mmf_datapath #(
    .NUM_WORDS(NUM_WORDS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .j             (j),
    .k             (k),
    .q_widx        (q_widx),
    .operand       (operand),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result_strobe (result_strobe),
    .result        (result)
  );

`ifndef NO_ASSERTIONS
  a_strobe_from_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(busy))
    else $error("result beat without a running product");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.last_result) |=> !result_strobe)
    else $error("result beat after the top word");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !operand.last_word) |=> !busy)
    else $error("non-final operand beat started a product");

  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operand.last_word) |=> busy)
    else $error("final operand beat did not start a product");
`endif

endmodule
`default_nettype wire

// ===== rtl/mmf_datapath.sv =====
// Datapath: operand and quotient stores, shared 32x32 multiplier, column accumulator.
`default_nettype none
module mmf_datapath #(
  parameter int NUM_WORDS = 4,
  localparam int IW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1,
  localparam int CW = $clog2(NUM_WORDS + 1)
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire mmf_pkg::cmd_t                    cmd,
  input  wire logic [IW-1:0]                    j,
  input  wire logic [IW-1:0]                    k,
  input  wire logic [IW-1:0]                    q_widx,
  input  wire mmf_pkg::in_t                     operand,
  input  wire logic                             cfg_we,
  input  wire logic [mmf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [mmf_pkg::WORD_W-1:0]       cfg_data,
  output logic                                  result_strobe,
  output mmf_pkg::out_t                         result
);

  logic [mmf_pkg::WORD_W-1:0] a_st [NUM_WORDS];
  logic [mmf_pkg::WORD_W-1:0] b_st [NUM_WORDS];
  logic [mmf_pkg::WORD_W-1:0] q_st [NUM_WORDS];
  logic [mmf_pkg::WORD_W-1:0] n_reg [NUM_WORDS];
  logic [mmf_pkg::WORD_W-1:0] n0;
  logic [CW-1:0]              count;

  logic [mmf_pkg::ACC_W-1:0]  acc;
  logic [mmf_pkg::WORD_W-1:0] qacc;
  logic [mmf_pkg::WORD_W-1:0] prod;
  logic                       p_valid;
  logic                       p_dest_q;
  logic [1:0]                 p_shift;

  logic ge;
  logic decided;
  logic borrow;

  logic [mmf_pkg::WORD_W-1:0] a_rd, b_rd, x, y;
  logic [mmf_pkg::HALF_W-1:0] x_half, y_half;
  logic [mmf_pkg::WORD_W-1:0] mul_out;
  logic [mmf_pkg::ACC_W-1:0]  addend;
  logic [mmf_pkg::WORD_W-1:0] q_addend;
  logic [mmf_pkg::WORD_W:0]   diff;
  logic                       sub;
  logic                       b_in;

  assign a_rd = (CW'(j) < count) ? a_st[j] : '0;
  assign b_rd = (CW'(k) < count) ? b_st[k] : '0;

  always_comb begin
    case (cmd.mul_src)
      mmf_pkg::SRC_AB: begin
        x = a_rd;
        y = b_rd;
      end
      mmf_pkg::SRC_QN: begin
        x = q_st[j];
        y = n_reg[k];
      end
      default: begin
        x = acc[mmf_pkg::WORD_W-1:0];
        y = n0;
      end
    endcase
  end

  assign x_half  = cmd.part[1] ? x[63:32] : x[31:0];
  assign y_half  = cmd.part[0] ? y[63:32] : y[31:0];
  assign mul_out = x_half * y_half;

  always_comb begin
    case (p_shift)
      2'd0:    addend = {128'b0, prod};
      2'd1:    addend = {96'b0, prod, 32'b0};
      default: addend = {64'b0, prod, 64'b0};
    endcase
  end

  assign q_addend = (p_shift == 2'd0) ? prod : {prod[31:0], 32'b0};

  assign sub  = ge || (acc[mmf_pkg::WORD_W-1:0] != '0);
  assign b_in = cmd.out_first ? 1'b0 : borrow;
  assign diff = {1'b0, q_st[j]} - {1'b0, n_reg[k]} - {64'b0, b_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      p_valid <= 1'b0;
      acc     <= '0;
      n0      <= '0;
      for (int e = 0; e < NUM_WORDS; e++) begin
        n_reg[e] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == mmf_pkg::REG_NEG_INV) begin
          n0 <= cfg_data;
        end else if (cfg_index < 3'(NUM_WORDS)) begin
          n_reg[cfg_index[IW-1:0]] <= cfg_data;
        end
      end

      if (cmd.count_clear) begin
        count <= '0;
      end else if (cmd.load_en && (count < CW'(NUM_WORDS))) begin
        count <= count + CW'(1);
      end

      p_valid <= cmd.mul_en;

      if (cmd.acc_clear) begin
        acc <= '0;
      end else if (cmd.acc_shift) begin
        acc <= {64'b0, acc[mmf_pkg::ACC_W-1:mmf_pkg::WORD_W]};
      end else if (p_valid && !p_dest_q) begin
        acc <= acc + addend;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_en && (count < CW'(NUM_WORDS))) begin
      a_st[count[IW-1:0]] <= operand.a_word;
      b_st[count[IW-1:0]] <= operand.b_word;
    end

    if (cmd.mul_en) begin
      prod     <= mul_out;
      p_dest_q <= (cmd.mul_src == mmf_pkg::SRC_Q0);
      p_shift  <= {1'b0, cmd.part[0]} + {1'b0, cmd.part[1]};
    end

    if (cmd.qacc_clear) begin
      qacc <= '0;
    end else if (p_valid && p_dest_q) begin
      qacc <= qacc + q_addend;
    end

    if (cmd.q_write) begin
      q_st[q_widx] <= cmd.q_from_acc ? acc[mmf_pkg::WORD_W-1:0] : qacc;
    end

    if (cmd.cmp_init) begin
      ge      <= 1'b1;
      decided <= 1'b0;
    end else if (cmd.cmp_en && !decided && (q_st[j] != n_reg[k])) begin
      ge      <= q_st[j] > n_reg[k];
      decided <= 1'b1;
    end

    if (cmd.out_en) begin
      borrow             <= diff[mmf_pkg::WORD_W];
      result.result_word <= sub ? diff[mmf_pkg::WORD_W-1:0] : q_st[j];
      result.last_result <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.out_en;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mmf_ctrl.sv =====
// Controller: sequences column MACs, quotient words, final compare and result beats.
`default_nettype none
module mmf_ctrl #(
  parameter int NUM_WORDS = 4,
  localparam int IW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1,
  localparam int IIW = $clog2(2 * NUM_WORDS)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          last_word,
  output logic               busy,
  output mmf_pkg::cmd_t      cmd,
  output logic [IW-1:0]      j,
  output logic [IW-1:0]      k,
  output logic [IW-1:0]      q_widx
);

  localparam logic [IW-1:0]  J_LAST = IW'(NUM_WORDS - 1);
  localparam logic [IIW-1:0] I_LAST = IIW'(2 * NUM_WORDS - 1);
  localparam logic [IIW-1:0] I_W    = IIW'(NUM_WORDS);

  mmf_pkg::state_t state, state_next;
  logic [IIW-1:0]  i, i_next;
  logic [IW-1:0]   j_next, k_next;
  logic [1:0]      p, p_next;

  logic           low;
  logic           at_diag;
  logic [IIW-1:0] i_inc;
  logic [IIW:0]   hj;

  assign busy    = (state != mmf_pkg::ST_IDLE);
  assign low     = (i < I_W);
  assign at_diag = (IIW'(j) == i);
  assign i_inc   = i + IIW'(1);
  assign hj      = {1'b0, i_inc} - (IIW + 1)'(NUM_WORDS) + (IIW + 1)'(1);
  assign q_widx  = low ? IW'(i) : IW'(i - I_W);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmf_pkg::ST_IDLE;
      i     <= '0;
      j     <= '0;
      k     <= '0;
      p     <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      k     <= k_next;
      p     <= p_next;
    end
  end

  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    k_next     = k;
    p_next     = p;
    cmd        = '0;
    case (state)
      mmf_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load_en = 1'b1;
          if (last_word) begin
            cmd.acc_clear = 1'b1;
            i_next        = '0;
            j_next        = '0;
            k_next        = '0;
            p_next        = '0;
            state_next    = mmf_pkg::ST_AB;
          end
        end
      end
      mmf_pkg::ST_AB: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_src = mmf_pkg::SRC_AB;
        cmd.part    = p;
        p_next      = p + 2'd1;
        if (p == 2'd3) begin
          state_next = (low && at_diag) ? mmf_pkg::ST_QWAIT : mmf_pkg::ST_QN;
        end
      end
      mmf_pkg::ST_QN: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_src = mmf_pkg::SRC_QN;
        cmd.part    = p;
        p_next      = p + 2'd1;
        if (p == 2'd3) begin
          if ((low && at_diag) || (!low && (j == J_LAST))) begin
            state_next = mmf_pkg::ST_END;
          end else begin
            j_next     = j + IW'(1);
            k_next     = k - IW'(1);
            state_next = mmf_pkg::ST_AB;
          end
        end
      end
      mmf_pkg::ST_QWAIT: begin
        cmd.qacc_clear = 1'b1;
        p_next         = '0;
        state_next     = mmf_pkg::ST_QMUL;
      end
      mmf_pkg::ST_QMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_src = mmf_pkg::SRC_Q0;
        cmd.part    = p;
        if (p == 2'd2) begin
          p_next     = '0;
          state_next = mmf_pkg::ST_QDRAIN;
        end else begin
          p_next = p + 2'd1;
        end
      end
      mmf_pkg::ST_QDRAIN: begin
        state_next = mmf_pkg::ST_QWRITE;
      end
      mmf_pkg::ST_QWRITE: begin
        cmd.q_write = 1'b1;
        state_next  = mmf_pkg::ST_QN;
      end
      mmf_pkg::ST_END: begin
        state_next = mmf_pkg::ST_SHIFT;
      end
      mmf_pkg::ST_SHIFT: begin
        cmd.acc_shift  = 1'b1;
        cmd.q_write    = !low;
        cmd.q_from_acc = 1'b1;
        if (i == I_LAST) begin
          cmd.cmp_init = 1'b1;
          j_next       = J_LAST;
          k_next       = J_LAST;
          state_next   = mmf_pkg::ST_CMP;
        end else begin
          i_next = i_inc;
          if (i_inc < I_W) begin
            j_next     = '0;
            k_next     = IW'(i_inc);
            state_next = mmf_pkg::ST_AB;
          end else if (hj > (IIW + 1)'(NUM_WORDS - 1)) begin
            state_next = mmf_pkg::ST_SHIFT;
          end else begin
            j_next     = IW'(hj);
            k_next     = J_LAST;
            state_next = mmf_pkg::ST_AB;
          end
        end
      end
      mmf_pkg::ST_CMP: begin
        cmd.cmp_en = 1'b1;
        if (j == '0) begin
          state_next = mmf_pkg::ST_OUT;
        end else begin
          j_next = j - IW'(1);
          k_next = k - IW'(1);
        end
      end
      mmf_pkg::ST_OUT: begin
        cmd.out_en    = 1'b1;
        cmd.out_first = (j == '0);
        cmd.out_last  = (j == J_LAST);
        if (j == J_LAST) begin
          cmd.count_clear = 1'b1;
          state_next      = mmf_pkg::ST_IDLE;
        end else begin
          j_next = j + IW'(1);
          k_next = k + IW'(1);
        end
      end
      default: begin
        state_next = mmf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== bench/tb_montgomery_multiplier_fips.sv =====
// Self-checking testbench for the word-serial Montgomery multiplier.
module tb_montgomery_multiplier_fips;
  timeunit 1ns;
  timeprecision 1ps;
  import mmf_pkg::*;

  localparam int NW = 4;
  localparam int LATENCY = 8 * NW * NW + 12 * NW + 24;
  localparam int IDLE_LIMIT = 4000;
  localparam int RAND_BEATS = 48;
  localparam int MAX_PRINTS = 40;
  localparam logic [CFG_INDEX_W-1:0] REG_MOD0 = 3'd0;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  in_t                    operand = '0;
  logic                   result_strobe;
  out_t                   result;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]      cfg_data = '0;

  in_t               pending_beats[$];
  out_t              expected_words[$];
  logic [WORD_W-1:0] mod_shadow [4];
  logic [WORD_W-1:0] n0_shadow;
  logic [WORD_W-1:0] a_store [NW];
  logic [WORD_W-1:0] b_store [NW];
  int                load_count;
  int                errors = 0;
  int                cfg_writes = 0;
  logic              in_taken = 1'b0;
  int                gap_left = 0;
  bit                gap_mode = 1'b0;
  int                idle_cycles = 0;

  montgomery_multiplier_fips #(.NUM_WORDS(NW)) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operand(operand),
    .result_strobe(result_strobe),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report(input string what, input logic [WORD_W-1:0] got,
                        input logic [WORD_W-1:0] want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
  endtask

  function automatic logic [3*WORD_W-1:0] word_product(input logic [WORD_W-1:0] x,
                                                       input logic [WORD_W-1:0] y);
    return {{WORD_W{1'b0}}, {{WORD_W{1'b0}}, x} * {{WORD_W{1'b0}}, y}};
  endfunction

  // Loads one beat; on the final beat forms a*b*R^-1 and queues the result words.
  task automatic montgomery_step(input in_t beat);
    logic [3*WORD_W-1:0] acc;
    logic [WORD_W-1:0]   q [NW];
    logic [WORD_W-1:0]   r [NW];
    logic [WORD_W:0]     diff;
    logic                ge, decided, sub, borrow;
    out_t                word;
    int                  i, j;
    if (load_count < NW) begin
      a_store[load_count] = beat.a_word;
      b_store[load_count] = beat.b_word;
      load_count++;
    end
    if (!beat.last_word) return;
    for (i = load_count; i < NW; i++) begin
      a_store[i] = '0;
      b_store[i] = '0;
    end
    acc = '0;
    for (i = 0; i < NW; i++) begin
      for (j = 0; j < i; j++) begin
        acc = acc + word_product(a_store[j], b_store[i-j]);
        acc = acc + word_product(q[j], mod_shadow[i-j]);
      end
      acc = acc + word_product(a_store[i], b_store[0]);
      q[i] = acc[WORD_W-1:0] * n0_shadow;
      acc = acc + word_product(q[i], mod_shadow[0]);
      acc = acc >> WORD_W;
    end
    for (i = NW; i < 2 * NW; i++) begin
      for (j = i - NW + 1; j < NW; j++) begin
        acc = acc + word_product(a_store[j], b_store[i-j]);
        acc = acc + word_product(q[j], mod_shadow[i-j]);
      end
      r[i-NW] = acc[WORD_W-1:0];
      acc = acc >> WORD_W;
    end
    ge = 1'b1;
    decided = 1'b0;
    for (i = NW - 1; i >= 0; i--) begin
      if (!decided && r[i] != mod_shadow[i]) begin
        ge = r[i] > mod_shadow[i];
        decided = 1'b1;
      end
    end
    sub = ge || acc[WORD_W-1:0] != '0;
    borrow = 1'b0;
    for (i = 0; i < NW; i++) begin
      if (sub) begin
        diff = {1'b0, r[i]} - {1'b0, mod_shadow[i]} - {{WORD_W{1'b0}}, borrow};
        r[i] = diff[WORD_W-1:0];
        borrow = diff[WORD_W];
      end
      word.result_word = r[i];
      word.last_result = (i == NW - 1);
      expected_words.push_back(word);
    end
    load_count = 0;
  endtask

  always @(posedge clk) begin
    out_t want;
    int   k;
    if (rst) begin
      in_taken <= 1'b0;
      load_count = 0;
      n0_shadow = '0;
      for (k = 0; k < 4; k++) mod_shadow[k] = '0;
    end else begin
      in_taken <= start && !busy;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_NEG_INV) n0_shadow = cfg_data;
        else if (cfg_index < REG_NEG_INV) mod_shadow[cfg_index - REG_MOD0] = cfg_data;
        cfg_writes++;
      end
      if (start && !busy) montgomery_step(operand);
      if (result_strobe) begin
        if (expected_words.size() == 0) begin
          report("unexpected result beat", result.result_word, '0);
        end else begin
          want = expected_words.pop_front();
          if (result.result_word !== want.result_word)
            report("result_word", result.result_word, want.result_word);
          if (result.last_result !== want.last_result)
            report("last_result", WORD_W'(result.last_result), WORD_W'(want.last_result));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("** montgomery_multiplier_fips: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!gap_mode || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (!start || in_taken) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_beats.size() > 0) begin
        operand <= pending_beats.pop_front();
        start <= 1'b1;
        gap_left <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return WORD_W'($urandom_range(0, 15));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] neg_inverse(input logic [WORD_W-1:0] n);
    logic [WORD_W-1:0] inv;
    inv = n;
    repeat (5) inv = inv * (WORD_W'(2) - n * inv);
    return -inv;
  endfunction

  task automatic push_beat(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b,
                           input logic last);
    in_t beat;
    beat.a_word = a;
    beat.b_word = b;
    beat.last_word = last;
    pending_beats.push_back(beat);
  endtask

  // Mostly full-length operands; the rest short or overlong.
  task automatic push_random_op(output int beats);
    int kind, k;
    kind = $urandom_range(0, 19);
    if (kind < 15) beats = NW;
    else if (kind < 18) beats = $urandom_range(1, NW - 1);
    else beats = $urandom_range(NW + 1, NW + 3);
    for (k = 1; k <= beats; k++) push_beat(rand_word(), rand_word(), k == beats);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [WORD_W-1:0] data);
    int seen;
    seen = cfg_writes;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    while (cfg_writes == seen) @(negedge clk);
  endtask

  task automatic load_modulus(input logic [4*WORD_W-1:0] n, input logic [WORD_W-1:0] n0);
    int k;
    for (k = 0; k < 4; k++) write_reg(REG_MOD0 + CFG_INDEX_W'(k), n[k*WORD_W +: WORD_W]);
    write_reg(REG_NEG_INV, n0);
    cfg_valid <= 1'b0;
  endtask

  // Wait until the block is idle with nothing outstanding.
  task automatic settle();
    while (pending_beats.size() != 0 || start || busy || expected_words.size() != 0)
      @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  initial begin
    logic [4*WORD_W-1:0] n;
    logic [WORD_W-1:0]   n0;
    int                  p, sent, beats, k;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    n = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    n[0] = 1'b1;
    n[4*WORD_W-1] = 1'b1;
    load_modulus(n, neg_inverse(n[WORD_W-1:0]));
    gap_mode = 1'b1;
    @(posedge clk);
    for (k = 0; k < NW; k++) push_beat('0, '0, k == NW - 1);
    for (k = 0; k < NW; k++) push_beat('1, '1, k == NW - 1);
    for (k = 0; k < NW; k++)
      push_beat(n[k*WORD_W +: WORD_W] - WORD_W'(k == 0),
                n[k*WORD_W +: WORD_W] - WORD_W'(k == 0), k == NW - 1);
    push_beat(rand_word(), rand_word(), 1'b1);
    for (k = 0; k < 2; k++) push_beat(rand_word(), rand_word(), k == 1);
    for (k = 0; k < NW + 2; k++) push_beat(rand_word(), rand_word(), k == NW + 1);
    settle();

    for (p = 0; p < 7; p++) begin
      n = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      case (p)
        0: n = '1;
        1: n = {{(3*WORD_W){1'b0}}, n[WORD_W-1:0] | {1'b1, {(WORD_W-2){1'b0}}, 1'b1}};
        2: n = {{(4*WORD_W-1){1'b0}}, 1'b1};
        3: n = '0;
        4: n[0] = 1'b0;
        default: begin
          n[0] = 1'b1;
          n[4*WORD_W-1] = 1'b1;
        end
      endcase
      if (p == 3) n0 = '1;
      else if (p == 4) n0 = {$urandom, $urandom};
      else n0 = neg_inverse(n[WORD_W-1:0]);
      load_modulus(n, n0);
      gap_mode = (p % 2 == 1);
      @(posedge clk);
      sent = 0;
      while (sent < RAND_BEATS) begin
        push_random_op(beats);
        sent += beats;
      end
      settle();
    end

    if (errors == 0) $display("** montgomery_multiplier_fips: PASSED **");
    else $display("** montgomery_multiplier_fips: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mmf_pkg.sv
rtl/mmf_datapath.sv
rtl/mmf_ctrl.sv
rtl/montgomery_multiplier_fips.sv
bench/tb_montgomery_multiplier_fips.sv
